// ===== hw/rtl/cbq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and width helpers for the cubic Bezier to quadratic converter.
// No dependencies.

package cbq_pkg;

  localparam int SEG_SHIFT = 3;
  localparam int SEGMENT_COUNT = 1 << SEG_SHIFT;
  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int COEF_COUNT = 10;

  typedef enum logic {
    CMD_MOVE = 1'b0,
    CMD_QUAD = 1'b1
  } cmd_t;

  // Internal values carry 3*SEG_SHIFT + 2 extra fraction bits and one guard bit.
  function automatic int acc_width(input int cw);
    return cw + 3 * SEG_SHIFT + 3;
  endfunction

  function automatic int item_width(input int cw);
    return COEF_COUNT * acc_width(cw) + 1;
  endfunction

endpackage

// ===== hw/rtl/cbq_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts a curve, forms its polynomial coefficients and the initial
// forward-difference terms for both axes. Depends on cbq_pkg.

module cbq_front import cbq_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [COORD_WIDTH-1:0]             start_x,
  input  logic signed [COORD_WIDTH-1:0]             start_y,
  input  logic signed [COORD_WIDTH-1:0]             first_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0]             first_ctrl_y,
  input  logic signed [COORD_WIDTH-1:0]             second_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0]             second_ctrl_y,
  input  logic signed [COORD_WIDTH-1:0]             finish_x,
  input  logic signed [COORD_WIDTH-1:0]             finish_y,
  input  logic                                      path_empty,
  output logic                                      push_valid,
  input  logic                                      push_ready,
  output logic [item_width(COORD_WIDTH)-1:0]        push_data
);

  localparam int ACC = acc_width(COORD_WIDTH);

  typedef logic signed [ACC-1:0] acc_t;

  function automatic acc_t sext(input logic [COORD_WIDTH-1:0] v);
    return {{(ACC - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic acc_t times3(input acc_t v);
    return (v <<< 1) + v;
  endfunction

  // Forward-difference start values: E(0), first, second, third difference,
  // and the derivative difference term H(0).
  function automatic logic [5*ACC-1:0] coeffs(input acc_t p0, input acc_t a,
                                               input acc_t b, input acc_t c);
    acc_t e;
    acc_t d1;
    acc_t d2;
    acc_t d3;
    acc_t h;
    e  = p0 <<< (3 * SEG_SHIFT);
    d1 = a + (b <<< SEG_SHIFT) + (c <<< (2 * SEG_SHIFT));
    d3 = (a <<< 2) + (a <<< 1);
    d2 = d3 + (b <<< (SEG_SHIFT + 1));
    h  = -(times3(a) + (b <<< (SEG_SHIFT + 1)));
    return {e, d1, d2, d3, h};
  endfunction

  acc_t p0_x, p1_x, p2_x, p3_x, p0_y, p1_y, p2_y, p3_y;
  acc_t a_x_in, b_x_in, c_x_in, a_y_in, b_y_in, c_y_in;
  acc_t a_x, b_x, c_x, org_x, a_y, b_y, c_y, org_y;
  logic s1_valid;
  logic s1_empty;

  always_comb begin
    p0_x = sext(start_x);
    p1_x = sext(first_ctrl_x);
    p2_x = sext(second_ctrl_x);
    p3_x = sext(finish_x);
    p0_y = sext(start_y);
    p1_y = sext(first_ctrl_y);
    p2_y = sext(second_ctrl_y);
    p3_y = sext(finish_y);
    a_x_in = p3_x - p0_x + times3(p1_x - p2_x);
    b_x_in = times3(p0_x - (p1_x <<< 1) + p2_x);
    c_x_in = times3(p1_x - p0_x);
    a_y_in = p3_y - p0_y + times3(p1_y - p2_y);
    b_y_in = times3(p0_y - (p1_y <<< 1) + p2_y);
    c_y_in = times3(p1_y - p0_y);
  end

  assign in_ready = !s1_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_x      <= a_x_in;
      b_x      <= b_x_in;
      c_x      <= c_x_in;
      org_x    <= p0_x;
      a_y      <= a_y_in;
      b_y      <= b_y_in;
      c_y      <= c_y_in;
      org_y    <= p0_y;
      s1_empty <= path_empty;
    end
  end

  assign push_valid = s1_valid;
  assign push_data  = {s1_empty, coeffs(org_x, a_x, b_x, c_x), coeffs(org_y, a_y, b_y, c_y)};

endmodule

// ===== hw/rtl/cbq_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue between the front end and the segment sequencer.
// Depends on cbq_pkg.

module cbq_queue import cbq_pkg::*; #(
  parameter int DATA_WIDTH = 1,
  parameter int DEPTH      = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output logic [DATA_WIDTH-1:0] pop_data
);

  localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);
  localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
  localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [PTR_WIDTH-1:0]  wr_ptr;
  logic [PTR_WIDTH-1:0]  rd_ptr;
  logic [CNT_WIDTH-1:0]  count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/cbq_back.sv =====
`timescale 1ns / 1ps
// Back end: steps the forward differences once per segment, emits the optional
// move-to and the quadratics into the output register. Depends on cbq_pkg.

module cbq_back import cbq_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  logic [item_width(COORD_WIDTH)-1:0] pop_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               command,
  output logic signed [COORD_WIDTH:0]        quad_ctrl_x,
  output logic signed [COORD_WIDTH:0]        quad_ctrl_y,
  output logic signed [COORD_WIDTH-1:0]      point_x,
  output logic signed [COORD_WIDTH-1:0]      point_y,
  output logic                               last_segment
);

  localparam int ACC = acc_width(COORD_WIDTH);
  localparam int PT_LO = 3 * SEG_SHIFT;
  localparam int QC_LO = 3 * SEG_SHIFT + 2;
  localparam logic [SEG_SHIFT-1:0] SEG_LAST = SEG_SHIFT'(SEGMENT_COUNT - 1);

  typedef logic signed [ACC-1:0] acc_t;

  acc_t e_x, d1_x, d2_x, d3_x, h_x;
  acc_t e_y, d1_y, d2_y, d3_y, h_y;
  acc_t sum_x, sum_y, nxt_x, nxt_y;
  logic                 busy;
  logic                 move_pending;
  logic [SEG_SHIFT-1:0] seg;
  logic                 out_free;
  logic                 step;
  logic                 finishing;
  logic                 load;

  assign out_free  = !out_valid || out_ready;
  assign step      = busy && out_free;
  assign finishing = step && !move_pending && (seg == SEG_LAST);
  assign pop_ready = !busy || finishing;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    nxt_x = e_x + d1_x;
    nxt_y = e_y + d1_y;
    sum_x = (e_x <<< 2) + (d1_x <<< 1) + h_x;
    sum_y = (e_y <<< 2) + (d1_y <<< 1) + h_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      move_pending <= 1'b0;
      seg          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        busy         <= 1'b1;
        move_pending <= pop_data[COEF_COUNT*ACC];
        seg          <= '0;
      end else if (finishing) begin
        busy <= 1'b0;
      end else if (step) begin
        if (move_pending) begin
          move_pending <= 1'b0;
        end else begin
          seg <= seg + 1'b1;
        end
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (load) begin
      {e_x, d1_x, d2_x, d3_x, h_x} <= pop_data[COEF_COUNT*ACC-1:5*ACC];
      {e_y, d1_y, d2_y, d3_y, h_y} <= pop_data[5*ACC-1:0];
    end else if (step && !move_pending) begin
      e_x  <= nxt_x;
      d1_x <= d1_x + d2_x;
      d2_x <= d2_x + d3_x;
      h_x  <= h_x - d3_x;
      e_y  <= nxt_y;
      d1_y <= d1_y + d2_y;
      d2_y <= d2_y + d3_y;
      h_y  <= h_y - d3_y;
    end

    if (step) begin
      if (move_pending) begin
        command      <= CMD_MOVE;
        quad_ctrl_x  <= '0;
        quad_ctrl_y  <= '0;
        point_x      <= e_x[COORD_WIDTH+PT_LO-1:PT_LO];
        point_y      <= e_y[COORD_WIDTH+PT_LO-1:PT_LO];
        last_segment <= 1'b0;
      end else begin
        command      <= CMD_QUAD;
        quad_ctrl_x  <= sum_x[COORD_WIDTH+QC_LO:QC_LO];
        quad_ctrl_y  <= sum_y[COORD_WIDTH+QC_LO:QC_LO];
        point_x      <= nxt_x[COORD_WIDTH+PT_LO-1:PT_LO];
        point_y      <= nxt_y[COORD_WIDTH+PT_LO-1:PT_LO];
        last_segment <= seg == SEG_LAST;
      end
    end
  end

endmodule

// ===== hw/rtl/cubic_bezier_to_quadratics_top.sv =====
`timescale 1ns / 1ps
// A curve passes the front-end register and the queue before the sequencer emits its results.
// The segment sequencer issues one result per cycle into the single output register while that
// register is free, and takes the next curve from the queue while it emits the last quadratic.
// Reset clears the pipeline valid flags, the queue count and the sequencer; no clearing pass.
// Top level: front end, queue and segment sequencer. Depends on cbq_pkg and the cbq modules.

module cubic_bezier_to_quadratics_top import cbq_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] first_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] first_ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] second_ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] second_ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] finish_x,
  input  logic signed [COORD_WIDTH-1:0] finish_y,
  input  logic                          path_empty,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          command,
  output logic signed [COORD_WIDTH:0]   quad_ctrl_x,
  output logic signed [COORD_WIDTH:0]   quad_ctrl_y,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic                          last_segment
);

  localparam int ITEM_WIDTH = item_width(COORD_WIDTH);

  logic                  push_valid;
  logic                  push_ready;
  logic [ITEM_WIDTH-1:0] push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ITEM_WIDTH-1:0] pop_data;

  cbq_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_x      (start_x),
    .start_y      (start_y),
    .first_ctrl_x (first_ctrl_x),
    .first_ctrl_y (first_ctrl_y),
    .second_ctrl_x(second_ctrl_x),
    .second_ctrl_y(second_ctrl_y),
    .finish_x     (finish_x),
    .finish_y     (finish_y),
    .path_empty   (path_empty),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  cbq_queue #(
    .DATA_WIDTH(ITEM_WIDTH),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  cbq_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .command     (command),
    .quad_ctrl_x (quad_ctrl_x),
    .quad_ctrl_y (quad_ctrl_y),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_segment(last_segment)
  );

endmodule
